// ===== hdl/nqe_pkg.sv =====
// Shared types and constants for the N-queens solution enumerator.
// No dependencies; imported by nqe_mask_unit, n_queens_solution_enumerator and its bench.
package nqe_pkg;

    // Default and limits of the largest supported board.
    localparam int MAX_QUEENS_DEF = 8;

    // Configuration register: board size in use.
    localparam int          BOARD_SIZE_W     = 4;
    localparam logic [3:0]  BOARD_SIZE_RESET = 4'd8;

    // Result format: three bits of row per column, eight columns reported.
    localparam int PLACE_ROW_W = 3;
    localparam int PLACE_COLS  = 8;
    localparam int PLACEMENT_W = PLACE_ROW_W * PLACE_COLS;

    // Width of a counter that holds 0 to max_q inclusive.
    function automatic int count_width(input int max_q);
        return $clog2(max_q + 1);
    endfunction

    // Width of a row index 0 to max_q - 1, at least one bit.
    function automatic int index_width(input int max_q);
        return (max_q > 1) ? $clog2(max_q) : 1;
    endfunction

endpackage

// ===== hdl/nqe_mask_unit.sv =====
// Shared conflict test and mask update for one (row, column) square.
// Depends on nqe_pkg for the width helpers.
module nqe_mask_unit #(
    parameter int MAX_QUEENS = nqe_pkg::MAX_QUEENS_DEF
) (
    input  logic [nqe_pkg::count_width(MAX_QUEENS)-1:0] row,
    input  logic [nqe_pkg::count_width(MAX_QUEENS)-1:0] col,
    input  logic [MAX_QUEENS-1:0]                       rows_taken,
    input  logic [2*MAX_QUEENS-2:0]                     sum_diag_taken,
    input  logic [2*MAX_QUEENS-2:0]                     diff_diag_taken,
    output logic                                        free,
    output logic [MAX_QUEENS-1:0]                       rows_set,
    output logic [2*MAX_QUEENS-2:0]                     sum_diag_set,
    output logic [2*MAX_QUEENS-2:0]                     diff_diag_set,
    output logic [MAX_QUEENS-1:0]                       rows_clr,
    output logic [2*MAX_QUEENS-2:0]                     sum_diag_clr,
    output logic [2*MAX_QUEENS-2:0]                     diff_diag_clr
);
    import nqe_pkg::*;

    localparam int CntW  = count_width(MAX_QUEENS);
    localparam int IdxW  = CntW + 1;
    localparam int DiagW = 2 * MAX_QUEENS - 1;

    logic [IdxW-1:0]       sum_idx;
    logic [IdxW-1:0]       diff_idx;
    logic [MAX_QUEENS-1:0] row_bit;
    logic [DiagW-1:0]      sum_bit;
    logic [DiagW-1:0]      diff_bit;

    // Diagonal indexes: row plus column, and row minus column offset to stay positive.
    assign sum_idx  = IdxW'(row) + IdxW'(col);
    assign diff_idx = IdxW'(row) + IdxW'(MAX_QUEENS - 1) - IdxW'(col);

    // One-hot selects of the square's row and its two diagonals.
    assign row_bit  = MAX_QUEENS'(1) << row;
    assign sum_bit  = DiagW'(1) << sum_idx;
    assign diff_bit = DiagW'(1) << diff_idx;

    // The square is free when none of its three lines is occupied.
    assign free = ((rows_taken & row_bit) == '0)
               && ((sum_diag_taken & sum_bit) == '0)
               && ((diff_diag_taken & diff_bit) == '0);

    // Masks with the queen placed on, or lifted from, this square.
    assign rows_set      = rows_taken | row_bit;
    assign sum_diag_set  = sum_diag_taken | sum_bit;
    assign diff_diag_set = diff_diag_taken | diff_bit;
    assign rows_clr      = rows_taken & ~row_bit;
    assign sum_diag_clr  = sum_diag_taken & ~sum_bit;
    assign diff_diag_clr = diff_diag_taken & ~diff_bit;

endmodule

// ===== hdl/n_queens_solution_enumerator.sv =====
// Top level of the N-queens solution enumerator: sequencer, search stack and masks.
// Depends on nqe_pkg and instantiates nqe_mask_unit.
//
// Usage:
//   Each transfer on the s_ channel asks for one solution. With s_restart high
//   (or when no search is running) the search starts over and the first
//   placement of the board is returned; with s_restart low the next one is.
//   Each request yields exactly one transfer on the m_ channel: m_found with
//   m_placement (three row bits per column, column 0 lowest), or m_exhausted
//   once every solution has been delivered, repeated until a restart.
//   cfg_we writes the board size (0 counts as 1, values above MAX_QUEENS are
//   clamped) and makes the next request start a fresh search.
// Timing:
//   The shared mask unit tests one square or lifts one queen per cycle. A request
//   is first accepted; when it resumes a search the last queen is lifted; then
//   come the square tests and backtracks, the check for a full board, and the
//   load of the output register. A request to a search that is already exhausted
//   goes straight to the output register. s_ready is high only while the
//   sequencer is idle. The result sits in an output register, so a new request is
//   taken while m_valid waits; a finished search holds until the receiver takes
//   the previous result.
// Reset: search state and board size (8) are set, no result is pending.
module n_queens_solution_enumerator #(
    parameter int MAX_QUEENS = nqe_pkg::MAX_QUEENS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [nqe_pkg::BOARD_SIZE_W-1:0] cfg_wdata,
    // Request channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_restart,
    // Result channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [nqe_pkg::PLACEMENT_W-1:0]  m_placement,
    output logic                             m_found,
    output logic                             m_exhausted
);
    import nqe_pkg::*;

    localparam int CntW     = count_width(MAX_QUEENS);
    localparam int RowW     = index_width(MAX_QUEENS);
    localparam int DiagW    = 2 * MAX_QUEENS - 1;
    localparam int PackCols = (MAX_QUEENS < PLACE_COLS) ? MAX_QUEENS : PLACE_COLS;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_POP    = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]              st_reg, st_next;
    logic [CntW-1:0]         col_reg, col_next;
    logic [CntW-1:0]         row_reg, row_next;
    logic [RowW-1:0]         stack_reg [MAX_QUEENS];
    logic [MAX_QUEENS-1:0]   rows_reg, rows_next;
    logic [DiagW-1:0]        sum_reg, sum_next;
    logic [DiagW-1:0]        diff_reg, diff_next;
    logic                    started_reg, started_next;
    logic                    done_reg, done_next;
    logic                    got_reg, got_next;
    logic [BOARD_SIZE_W-1:0] bsize_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [PLACEMENT_W-1:0]  m_placement_reg, m_placement_next;
    logic                    m_found_reg, m_found_next;
    logic                    m_exhausted_reg, m_exhausted_next;

    logic                    s_transfer;
    logic                    out_free;
    logic [CntW-1:0]         n_eff;
    logic [CntW-1:0]         col_m1;
    logic [CntW-1:0]         top_row;
    logic                    pop_sel;
    logic                    stack_we;
    logic [CntW-1:0]         mu_row, mu_col;
    logic                    mu_free;
    logic [MAX_QUEENS-1:0]   mu_rows_set, mu_rows_clr;
    logic [DiagW-1:0]        mu_sum_set, mu_sum_clr, mu_diff_set, mu_diff_clr;
    logic [PLACEMENT_W-1:0]  packed_rows;

    assign s_ready    = (st_reg == ST_IDLE);
    assign s_transfer = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;

    // Effective board size: zero counts as one, large values clamp.
    always_comb begin
        if (bsize_reg == '0) begin
            n_eff = CntW'(1);
        end else if (int'(bsize_reg) > MAX_QUEENS) begin
            n_eff = CntW'(MAX_QUEENS);
        end else begin
            n_eff = CntW'(bsize_reg);
        end
    end

    // Top of the stack: the queen of the previous column.
    assign col_m1  = col_reg - CntW'(1);
    assign top_row = CntW'(stack_reg[col_m1[RowW-1:0]]);

    // The mask unit looks at the top of the stack when backtracking.
    assign pop_sel = (st_reg == ST_POP) || (row_reg >= n_eff);
    assign mu_row  = pop_sel ? top_row : row_reg;
    assign mu_col  = pop_sel ? col_m1 : col_reg;

    nqe_mask_unit #(
        .MAX_QUEENS(MAX_QUEENS)
    ) u_mask (
        .row            (mu_row),
        .col            (mu_col),
        .rows_taken     (rows_reg),
        .sum_diag_taken (sum_reg),
        .diff_diag_taken(diff_reg),
        .free           (mu_free),
        .rows_set       (mu_rows_set),
        .sum_diag_set   (mu_sum_set),
        .diff_diag_set  (mu_diff_set),
        .rows_clr       (mu_rows_clr),
        .sum_diag_clr   (mu_sum_clr),
        .diff_diag_clr  (mu_diff_clr)
    );

    // Pack the rows of the reported columns for the result.
    always_comb begin
        packed_rows = '0;
        for (int c = 0; c < PackCols; c++) begin
            if (CntW'(c) < n_eff) begin
                packed_rows[PLACE_ROW_W*c +: PLACE_ROW_W] = PLACE_ROW_W'(stack_reg[c]);
            end
        end
    end

    // Sequencer: takes requests, searches with one square test or one backtrack per cycle, and loads the result.
    always_comb begin
        st_next          = st_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        rows_next        = rows_reg;
        sum_next         = sum_reg;
        diff_next        = diff_reg;
        started_next     = started_reg;
        done_next        = done_reg;
        got_next         = got_reg;
        stack_we         = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_placement_next = m_placement_reg;
        m_found_next     = m_found_reg;
        m_exhausted_next = m_exhausted_reg;

        case (st_reg)
            ST_IDLE: begin
                if (s_transfer) begin
                    if (s_restart || !started_reg) begin
                        // Fresh search from an empty board.
                        rows_next    = '0;
                        sum_next     = '0;
                        diff_next    = '0;
                        col_next     = '0;
                        row_next     = '0;
                        started_next = 1'b1;
                        done_next    = 1'b0;
                        st_next      = ST_SEARCH;
                    end else if (!done_reg) begin
                        // Resume by lifting the last queen.
                        st_next = ST_POP;
                    end else begin
                        got_next = 1'b0;
                        st_next  = ST_EMIT;
                    end
                end
            end
            ST_SEARCH: begin
                if (col_reg >= n_eff) begin
                    got_next = 1'b1;
                    st_next  = ST_EMIT;
                end else if (row_reg >= n_eff) begin
                    // Column out of rows: backtrack.
                    if (col_reg == '0) begin
                        got_next  = 1'b0;
                        done_next = 1'b1;
                        st_next   = ST_EMIT;
                    end else begin
                        rows_next = mu_rows_clr;
                        sum_next  = mu_sum_clr;
                        diff_next = mu_diff_clr;
                        col_next  = col_m1;
                        row_next  = top_row + CntW'(1);
                    end
                end else if (mu_free) begin
                    // Place the queen and move to the next column.
                    rows_next = mu_rows_set;
                    sum_next  = mu_sum_set;
                    diff_next = mu_diff_set;
                    stack_we  = 1'b1;
                    col_next  = col_reg + CntW'(1);
                    row_next  = '0;
                end else begin
                    row_next = row_reg + CntW'(1);
                end
            end
            ST_POP: begin
                if (col_reg == '0) begin
                    got_next  = 1'b0;
                    done_next = 1'b1;
                    st_next   = ST_EMIT;
                end else begin
                    rows_next = mu_rows_clr;
                    sum_next  = mu_sum_clr;
                    diff_next = mu_diff_clr;
                    col_next  = col_m1;
                    row_next  = top_row + CntW'(1);
                    st_next   = ST_SEARCH;
                end
            end
            ST_EMIT: begin
                // Load the output register once the previous result has gone.
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_placement_next = got_reg ? packed_rows : '0;
                    m_found_next     = got_reg;
                    m_exhausted_next = !got_reg;
                    st_next          = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // A size write forces a fresh search on the next request.
        if (cfg_we) begin
            started_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            rows_reg    <= '0;
            sum_reg     <= '0;
            diff_reg    <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            got_reg     <= 1'b0;
            bsize_reg   <= BOARD_SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            rows_reg    <= rows_next;
            sum_reg     <= sum_next;
            diff_reg    <= diff_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            got_reg     <= got_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                bsize_reg <= cfg_wdata;
            end
        end
    end

    // Search stack and result payload.
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_reg[col_reg[RowW-1:0]] <= RowW'(row_reg);
        end
        m_placement_reg <= m_placement_next;
        m_found_reg     <= m_found_next;
        m_exhausted_reg <= m_exhausted_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_placement = m_placement_reg;
    assign m_found     = m_found_reg;
    assign m_exhausted = m_exhausted_reg;

    // Every placed queen occupies exactly one row and one line of each diagonal kind.
    a_rows_match_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(rows_reg) == int'(col_reg))
        else $error("row mask does not match stack depth");

    a_diags_match_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(sum_reg) == int'(col_reg)) && ($countones(diff_reg) == int'(col_reg)))
        else $error("diagonal masks do not match stack depth");

    // A result is either a solution or the end of the search.
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_found != m_exhausted))
        else $error("result must be exactly one of found or exhausted");

    // The end-of-search report carries an empty placement.
    a_exhausted_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_exhausted) |-> (m_placement == '0))
        else $error("exhausted result with nonzero placement");

    // An accepted request leaves the sequencer busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_transfer |=> !s_ready)
        else $error("sequencer idle right after accepting a request");

endmodule

// ===== bench/n_queens_solution_enumerator_tb.sv =====
// Self-checking bench for n_queens_solution_enumerator: predicts every result with its own
// column-wise backtracking search and compares each result transfer against it.
// Depends on nqe_pkg and the enumerator RTL only.
module n_queens_solution_enumerator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nqe_pkg::*;

    localparam int QUEENS       = MAX_QUEENS_DEF;
    localparam int DIAGS        = 2 * QUEENS - 1;
    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    // Request kinds carried by s_restart.
    localparam bit REQ_NEXT    = 1'b0;
    localparam bit REQ_RESTART = 1'b1;

    typedef struct packed {
        logic [PLACEMENT_W-1:0] placement;
        logic                   found;
        logic                   exhausted;
    } placement_t;

    // Tracks the search state of the block and holds the placements still owed.
    class placement_tracker;
        logic [PLACE_ROW_W-1:0]  row_of_col [QUEENS];
        logic [QUEENS-1:0]       rows_taken;
        logic [DIAGS-1:0]        sum_diag_taken;
        logic [DIAGS-1:0]        diff_diag_taken;
        logic [3:0]              placed_cols;
        bit                      started;
        bit                      finished;
        logic [BOARD_SIZE_W-1:0] board_size;
        placement_t              pending_placements [$];
        int                      mismatches;

        function new();
            clear_search();
            board_size = BOARD_SIZE_RESET;
            mismatches = 0;
        endfunction

        function void clear_search();
            for (int i = 0; i < QUEENS; i++) row_of_col[i] = '0;
            rows_taken      = '0;
            sum_diag_taken  = '0;
            diff_diag_taken = '0;
            placed_cols     = '0;
            started         = 1'b0;
            finished        = 1'b0;
        endfunction

        // A size of zero counts as one; sizes past the board are clamped.
        function int active_size();
            int n;
            n = int'(board_size);
            if (n == 0) n = 1;
            if (n > QUEENS) n = QUEENS;
            return n;
        endfunction

        function void write_size(logic [BOARD_SIZE_W-1:0] size);
            board_size = size;
            started    = 1'b0;
        endfunction

        function int pending();
            return pending_placements.size();
        endfunction

        // Appends a result to the owed list.
        function void owe_result(placement_t res);
            pending_placements.insert(pending_placements.size(), res);
        endfunction

        function void mark_square(int r, int c, bit occupied);
            rows_taken[r]                 = occupied;
            sum_diag_taken[r + c]         = occupied;
            diff_diag_taken[r + QUEENS - 1 - c] = occupied;
        endfunction

        function bit square_free(int r, int c);
            return !rows_taken[r] && !sum_diag_taken[r + c] &&
                   !diff_diag_taken[r + QUEENS - 1 - c];
        endfunction

        // Runs the backtracking search to the next full board; 0 when none is left.
        function bit next_placement(bit resume);
            int n;
            int col;
            int r;
            n   = active_size();
            col = int'(placed_cols);
            r   = 0;
            if (col > n) col = n;
            if (resume) begin
                if (col == 0) return 1'b0;
                col--;
                r = int'(row_of_col[col]);
                mark_square(r, col, 1'b0);
                r++;
            end
            while (1) begin
                if (col >= n) begin
                    placed_cols = 4'(n);
                    return 1'b1;
                end
                if (r >= n) begin
                    if (col == 0) begin
                        placed_cols = '0;
                        return 1'b0;
                    end
                    col--;
                    r = int'(row_of_col[col]);
                    mark_square(r, col, 1'b0);
                    r++;
                end else if (square_free(r, col)) begin
                    mark_square(r, col, 1'b1);
                    row_of_col[col] = PLACE_ROW_W'(r);
                    col++;
                    r = 0;
                end else begin
                    r++;
                end
            end
        endfunction

        // Called on each request transfer: advances the search and queues its result.
        function void note_request(bit restart);
            placement_t res;
            bit         got;
            got = 1'b0;
            if (restart || !started) begin
                clear_search();
                started = 1'b1;
                got = next_placement(1'b0);
                if (!got) finished = 1'b1;
            end else if (!finished) begin
                got = next_placement(1'b1);
                if (!got) finished = 1'b1;
            end
            res = '0;
            if (got) begin
                for (int c = 0; c < active_size() && c < PLACE_COLS; c++)
                    res.placement[PLACE_ROW_W*c +: PLACE_ROW_W] = row_of_col[c];
            end
            res.found     = got;
            res.exhausted = !got;
            owe_result(res);
        endfunction

        // Called on each result transfer: compares it with the oldest owed placement.
        function void check_placement(placement_t actual);
            placement_t want;
            bit         bad;
            if (pending_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result placement=%h found=%b exhausted=%b",
                             $realtime, actual.placement, actual.found, actual.exhausted);
                return;
            end
            want = pending_placements.pop_front();
            bad  = (actual.placement !== want.placement) || (actual.found !== want.found) ||
                   (actual.exhausted !== want.exhausted);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: mismatch exp=%h/%b/%b act=%h/%b/%b (placement/found/exhausted)",
                             $realtime, want.placement, want.found, want.exhausted,
                             actual.placement, actual.found, actual.exhausted);
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [BOARD_SIZE_W-1:0] cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_restart = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [PLACEMENT_W-1:0]  m_placement;
    logic                    m_found;
    logic                    m_exhausted;

    placement_tracker tracker = new();
    int request_burst = 0;
    int result_burst = 0;
    int quiet_cycles = 0;

    n_queens_solution_enumerator #(.MAX_QUEENS(QUEENS)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_placement (m_placement),
        .m_found     (m_found),
        .m_exhausted (m_exhausted)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Draws the idle wait before the next transfer from a uniform range, with runs of back-to-back ones.
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // Sends one request; valid stays high after the transfer unless the next call idles.
    task automatic send_request(input bit restart);
        int gap;
        gap = draw_wait(request_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!(s_valid && s_ready));
        tracker.note_request(restart);
    endtask

    // Writes the board size once every owed result has been taken.
    task automatic set_board_size(input logic [BOARD_SIZE_W-1:0] size);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        tracker.write_size(size);
        cfg_we <= 1'b0;
    endtask

    // Result side: random back-pressure, every transfer checked.
    initial begin
        placement_t actual;
        int         gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = draw_wait(result_burst);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            actual.placement = m_placement;
            actual.found     = m_found;
            actual.exhausted = m_exhausted;
            tracker.check_placement(actual);
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int               sent;
        int               count;
        int               restart_pct;
        int               size_n;
        bit               noisy;
        logic [3:0]       size;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Default size: a plain next before any search acts as a restart.
        send_request(REQ_NEXT);
        send_request(REQ_NEXT);
        send_request(REQ_RESTART);

        // Size zero behaves as a single square: one solution, then exhausted until restart.
        set_board_size(4'd0);
        send_request(REQ_NEXT);
        send_request(REQ_NEXT);
        send_request(REQ_NEXT);
        send_request(REQ_RESTART);

        // Oversized board is clamped to the full eight columns.
        set_board_size(4'd15);
        send_request(REQ_RESTART);
        send_request(REQ_NEXT);

        // Boards with no solution report exhaustion at once.
        set_board_size(4'd2);
        send_request(REQ_NEXT);
        send_request(REQ_NEXT);
        set_board_size(4'd3);
        send_request(REQ_RESTART);

        // Four queens: both solutions, then exhaustion, then a restart.
        set_board_size(4'd4);
        send_request(REQ_NEXT);
        send_request(REQ_NEXT);
        send_request(REQ_NEXT);
        send_request(REQ_NEXT);
        send_request(REQ_RESTART);

        set_board_size(4'd1);
        send_request(REQ_RESTART);
        send_request(REQ_NEXT);

        // A size write in the middle of a search makes the next request start over.
        set_board_size(4'd4);
        send_request(REQ_NEXT);
        set_board_size(4'd5);
        send_request(REQ_NEXT);

        // Random phases: mostly long runs of next requests, some restart noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       size = 4'($urandom_range(0, 15));
                1, 2:    size = 4'($urandom_range(4, 7));
                default: size = 4'd8;
            endcase
            if ($urandom_range(0, 3) != 0)
                set_board_size(size);
            size_n      = tracker.active_size();
            count       = (size_n >= QUEENS) ? $urandom_range(60, 130) : $urandom_range(5, 45);
            noisy       = ($urandom_range(0, 6) == 0);
            restart_pct = $urandom_range(0, 2);
            for (int i = 0; i < count && sent < RANDOM_ITEMS; i++) begin
                if (noisy)
                    send_request(1'($urandom_range(0, 1)));
                else
                    send_request(($urandom_range(0, 99) < restart_pct) ? REQ_RESTART : REQ_NEXT);
                sent++;
            end
        end

        // Let every owed result arrive, then give the block time to show anything extra.
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
